### rtl/tbvc_pkg.sv
package tbvc_pkg;

    localparam int RAW_W    = 12;
    localparam int SIZE_W   = 11;
    localparam int THR_W    = 16;
    localparam int SCR_W    = 10;
    localparam int IDLE_BITS = 16;
    localparam int CMP_W    = (IDLE_BITS > THR_W) ? IDLE_BITS : THR_W;
    localparam int MARGIN   = 20;
    localparam int LANES    = 2;

    // signed difference of two raw readings, signed usable span, product
    localparam int DIFF_W   = RAW_W + 1;
    localparam int SPAN_W   = SIZE_W + 1;
    localparam int PROD_W   = DIFF_W + SPAN_W;
    localparam int DVD_W    = PROD_W - 1;
    localparam int DIV_STEPS = DVD_W;
    localparam int STEP_W   = $clog2(DIV_STEPS);
    localparam int VAL_W    = DVD_W + 2;

    // floor(h / 3) as (h * THIRD_MUL) >> THIRD_SHIFT, exact for h below 2**SIZE_W
    localparam int THIRD_SHIFT = SIZE_W;
    localparam int THIRD_MUL   = (1 << THIRD_SHIFT) / 3 + 1;
    localparam int THIRD_MUL_W = THIRD_SHIFT;

    localparam int IN_W     = 2 * RAW_W;
    localparam int OUT_W    = 40;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RAW_LEFT      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_TOP       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_RIGHT     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_BOTTOM    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_AFTER     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_AFTER     = 4'd7;

    localparam logic [7:0] DUTY_FULL = 8'd255;
    localparam logic [7:0] DUTY_DIM  = 8'd20;
    localparam logic [7:0] DUTY_OFF  = 8'd0;

    typedef enum logic [1:0] {
        LIGHT_FULL = 2'd0,
        LIGHT_DIM  = 2'd1,
        LIGHT_OFF  = 2'd2
    } light_t;

    typedef enum logic [1:0] {
        METRIC_TEMP  = 2'd0,
        METRIC_HUMID = 2'd1,
        METRIC_PRESS = 2'd2
    } metric_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL,
        ST_MUL,
        ST_DINIT,
        ST_DIV,
        ST_FIX,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic [RAW_W-1:0]  raw_left;
        logic [RAW_W-1:0]  raw_top;
        logic [RAW_W-1:0]  raw_right;
        logic [RAW_W-1:0]  raw_bottom;
        logic [SIZE_W-1:0] screen_width;
        logic [SIZE_W-1:0] screen_height;
        logic [THR_W-1:0]  dim_after;
        logic [THR_W-1:0]  off_after;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_init;
        logic div_step;
        logic fix;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic touch;
        logic out_free;
    } sts_t;

    function automatic logic [7:0] duty_of(light_t l);
        logic [7:0] d;
        unique case (l)
            LIGHT_FULL: d = DUTY_FULL;
            LIGHT_DIM:  d = DUTY_DIM;
            LIGHT_OFF:  d = DUTY_OFF;
            default:    d = DUTY_FULL;
        endcase
        return d;
    endfunction

endpackage

### rtl/tbvc_ctrl.sv
module tbvc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  tbvc_pkg::sts_t sts,
    output tbvc_pkg::cmd_t cmd
);
    import tbvc_pkg::*;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEL;
                end
            end
            ST_SEL:
            begin
                state_next = sts.touch ? ST_MUL : ST_COMMIT;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DINIT;
            end
            ST_DINIT:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // hold until the output register can take the result
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/tbvc_dp.sv
module tbvc_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tbvc_pkg::cfg_t            cfg,
    input  tbvc_pkg::cmd_t            cmd,
    output tbvc_pkg::sts_t            sts,
    input  logic                      in_touch,
    input  logic [tbvc_pkg::IN_W-1:0] in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [tbvc_pkg::OUT_W-1:0] out_data
);
    import tbvc_pkg::*;

    logic                     touch_reg;
    logic [RAW_W-1:0]         raw_reg  [LANES];
    logic [RAW_W-1:0]         lo       [LANES];
    logic [RAW_W-1:0]         hi       [LANES];
    logic [SIZE_W-1:0]        size     [LANES];

    logic signed [DIFF_W-1:0] diff     [LANES];
    logic signed [SPAN_W-1:0] span     [LANES];
    logic signed [PROD_W-1:0] prod     [LANES];
    logic signed [DIFF_W-1:0] den      [LANES];

    logic signed [PROD_W-1:0] prod_reg [LANES];
    logic [RAW_W-1:0]         den_reg  [LANES];
    logic                     qneg_reg [LANES];
    logic                     zero_reg [LANES];
    logic [DVD_W-1:0]         dvd_reg  [LANES];
    logic [RAW_W-1:0]         rem_reg  [LANES];
    logic [SCR_W-1:0]         scr_reg  [LANES];

    logic [PROD_W-1:0]        pmag     [LANES];
    logic [RAW_W:0]           trial    [LANES];
    logic                     fits     [LANES];
    logic signed [VAL_W-1:0]  qs       [LANES];
    logic signed [VAL_W-1:0]  val      [LANES];
    logic [SCR_W-1:0]         top      [LANES];
    logic [SCR_W-1:0]         clamped  [LANES];

    light_t                   light_reg;
    logic [IDLE_BITS-1:0]     idle_reg;
    logic                     detail_reg;
    metric_t                  metric_reg;

    light_t                   light_new;
    logic [IDLE_BITS-1:0]     idle_new;
    logic                     detail_new;
    metric_t                  metric_new;
    metric_t                  metric_pick;
    logic [IDLE_BITS-1:0]     idle_inc;
    logic [SIZE_W+THIRD_MUL_W-1:0] third_prod;
    logic [SCR_W-1:0]         row;
    logic [SCR_W:0]           row2;

    logic                     out_valid_reg;
    logic [OUT_W-1:0]         out_data_reg;
    logic [OUT_W-1:0]         out_pack;

    assign lo[0]   = cfg.raw_left;
    assign hi[0]   = cfg.raw_right;
    assign size[0] = cfg.screen_width;
    assign lo[1]   = cfg.raw_top;
    assign hi[1]   = cfg.raw_bottom;
    assign size[1] = cfg.screen_height;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            diff[i]  = $signed({1'b0, raw_reg[i]}) - $signed({1'b0, lo[i]});
            span[i]  = $signed({1'b0, size[i]}) - $signed(SPAN_W'(2 * MARGIN));
            prod[i]  = diff[i] * span[i];
            den[i]   = $signed({1'b0, hi[i]}) - $signed({1'b0, lo[i]});
            pmag[i]  = prod_reg[i][PROD_W-1] ? PROD_W'(-prod_reg[i]) : PROD_W'(prod_reg[i]);
            trial[i] = {rem_reg[i], dvd_reg[i][DVD_W-1]};
            fits[i]  = trial[i] >= {1'b0, den_reg[i]};
            qs[i]    = qneg_reg[i] ? -$signed({2'b00, dvd_reg[i]})
                                   : $signed({2'b00, dvd_reg[i]});
            val[i]   = zero_reg[i] ? VAL_W'(MARGIN) : qs[i] + VAL_W'(MARGIN);
            if (size[i] == '0)
            begin
                top[i] = '0;
            end
            else if (size[i] > SIZE_W'(1 << SCR_W))
            begin
                top[i] = '1;
            end
            else
            begin
                top[i] = SCR_W'(size[i] - 1'b1);
            end
            priority if (val[i] < 0)
            begin
                clamped[i] = '0;
            end
            else if (val[i] > $signed({{(VAL_W-SCR_W){1'b0}}, top[i]}))
            begin
                clamped[i] = top[i];
            end
            else
            begin
                clamped[i] = SCR_W'(val[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            touch_reg  <= in_touch;
            raw_reg[0] <= in_data[RAW_W-1:0];
            raw_reg[1] <= in_data[2*RAW_W-1:RAW_W];
        end
        for (int i = 0; i < LANES; i++)
        begin
            if (cmd.mul)
            begin
                prod_reg[i] <= prod[i];
                den_reg[i]  <= den[i][DIFF_W-1] ? RAW_W'(-den[i]) : RAW_W'(den[i]);
                qneg_reg[i] <= prod[i][PROD_W-1] ^ den[i][DIFF_W-1];
                zero_reg[i] <= den[i] == '0;
            end
            if (cmd.div_init)
            begin
                dvd_reg[i] <= pmag[i][DVD_W-1:0];
                rem_reg[i] <= '0;
            end
            else if (cmd.div_step)
            begin
                // restoring step: shift in one dividend bit, subtract if it fits
                rem_reg[i] <= fits[i] ? RAW_W'(trial[i] - {1'b0, den_reg[i]})
                                      : RAW_W'(trial[i]);
                dvd_reg[i] <= {dvd_reg[i][DVD_W-2:0], fits[i]};
            end
            if (cmd.fix)
            begin
                scr_reg[i] <= clamped[i];
            end
        end
    end

    // screen third of the mapped y
    assign third_prod = cfg.screen_height * THIRD_MUL_W'(THIRD_MUL);
    assign row        = SCR_W'(third_prod >> THIRD_SHIFT);
    assign row2       = {row, 1'b0};
    assign idle_inc   = (idle_reg == '1) ? idle_reg : idle_reg + 1'b1;

    always_comb
    begin
        priority if (scr_reg[1] < row)
        begin
            metric_pick = METRIC_TEMP;
        end
        else if ({1'b0, scr_reg[1]} < row2)
        begin
            metric_pick = METRIC_HUMID;
        end
        else
        begin
            metric_pick = METRIC_PRESS;
        end

        light_new  = light_reg;
        idle_new   = idle_reg;
        detail_new = detail_reg;
        metric_new = metric_reg;
        if (touch_reg)
        begin
            idle_new  = '0;
            light_new = LIGHT_FULL;
            // a touch on a dark screen only wakes it
            if (light_reg != LIGHT_OFF)
            begin
                if (detail_reg)
                begin
                    detail_new = 1'b0;
                end
                else
                begin
                    detail_new = 1'b1;
                    metric_new = metric_pick;
                end
            end
        end
        else
        begin
            idle_new = idle_inc;
            priority if (CMP_W'(idle_inc) > CMP_W'(cfg.off_after))
            begin
                light_new = LIGHT_OFF;
            end
            else if (CMP_W'(idle_inc) > CMP_W'(cfg.dim_after))
            begin
                light_new = LIGHT_DIM;
            end
            else
            begin
                light_new = light_reg;
            end
        end

        out_pack = OUT_W'({touch_reg ? scr_reg[1] : SCR_W'(0),
                           touch_reg ? scr_reg[0] : SCR_W'(0),
                           touch_reg,
                           metric_new,
                           detail_new,
                           light_new != light_reg,
                           light_new,
                           duty_of(light_new)});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg     <= LIGHT_FULL;
            idle_reg      <= '0;
            detail_reg    <= 1'b0;
            metric_reg    <= METRIC_TEMP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                light_reg     <= light_new;
                idle_reg      <= idle_new;
                detail_reg    <= detail_new;
                metric_reg    <= metric_new;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg <= out_pack;
        end
    end

    assign sts.touch    = touch_reg;
    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

endmodule

### rtl/touch_backlight_view_controller_core.sv
// Touch backlight and view controller. Each s_axis item is one poll step; every
// step returns exactly one m_axis item with the backlight duty and mode, the view
// and metric, and for a touch the calibrated screen point. A step without touch
// goes straight from selection to commit. A touch runs both axes in parallel
// through a multiply stage and a 24-step restoring divider, one quotient bit per
// cycle; a new step is taken only once the last one has been committed.
// A finished result waits in the output register while the next step is taken.
// Configuration writes on cfg_* are always taken and are meant for an idle block.
module touch_backlight_view_controller_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tbvc_pkg::IN_W-1:0]      s_tdata,   // raw_x[11:0], raw_y[23:12]
    input  logic                           s_tuser,   // cmd[0]: 1 touch
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // duty[7:0], light_mode[9:8], light_changed[10], detail_view[11], metric[13:12],
    // touch_seen[14], screen_x[24:15], screen_y[34:25], zero[39:35]
    output logic [tbvc_pkg::OUT_W-1:0]     m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tbvc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tbvc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tbvc_pkg::*;

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.raw_left      <= RAW_W'(300);
            cfg_reg.raw_top       <= RAW_W'(300);
            cfg_reg.raw_right     <= RAW_W'(3800);
            cfg_reg.raw_bottom    <= RAW_W'(3800);
            cfg_reg.screen_width  <= SIZE_W'(320);
            cfg_reg.screen_height <= SIZE_W'(240);
            cfg_reg.dim_after     <= THR_W'(300);
            cfg_reg.off_after     <= THR_W'(2400);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_RAW_LEFT:      cfg_reg.raw_left      <= cfg_data[RAW_W-1:0];
                REG_RAW_TOP:       cfg_reg.raw_top       <= cfg_data[RAW_W-1:0];
                REG_RAW_RIGHT:     cfg_reg.raw_right     <= cfg_data[RAW_W-1:0];
                REG_RAW_BOTTOM:    cfg_reg.raw_bottom    <= cfg_data[RAW_W-1:0];
                REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data[SIZE_W-1:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data[SIZE_W-1:0];
                REG_DIM_AFTER:     cfg_reg.dim_after     <= cfg_data[THR_W-1:0];
                REG_OFF_AFTER:     cfg_reg.off_after     <= cfg_data[THR_W-1:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    tbvc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tbvc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .sts       (sts),
        .in_touch  (s_tuser),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous one still in work");

    a_no_touch_no_point: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[14] |-> m_tdata[34:15] == '0)
        else $error("screen point reported without touch");

    a_duty_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[9:8] == LIGHT_FULL && m_tdata[7:0] == DUTY_FULL)
                  || (m_tdata[9:8] == LIGHT_DIM && m_tdata[7:0] == DUTY_DIM)
                  || (m_tdata[9:8] == LIGHT_OFF && m_tdata[7:0] == DUTY_OFF))
        else $error("duty does not match backlight mode");

    a_touch_gives_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[14] |-> m_tdata[9:8] == LIGHT_FULL)
        else $error("touch did not restore full backlight");

endmodule
